// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ULCP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ulcp port check failed");

// The consequent must hold in the cycle after the antecedent.
`define ULCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ulcp port check failed");

`endif

// ----- rtl/ulcp_pkg.sv -----
`default_nettype none

package ulcp_pkg;

   localparam int LINE_MAX   = 64;
   localparam int ADDR_W     = $clog2(LINE_MAX);
   localparam int REPLY_MAX  = LINE_MAX - 1;
   localparam int MIN_TOKENS = 3;
   localparam int TOK_W      = $clog2(MIN_TOKENS + 1);
   localparam int TDATA_W    = 16;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LBR = 8'h5B;
   localparam logic [7:0] CH_AT  = 8'h40;
   localparam logic [7:0] CH_RBR = 8'h5D;

   typedef enum logic {
      KIND_LED  = 1'b0,
      KIND_BYTE = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      LIT_LED,
      LIT_NEW,
      LIT_ALR,
      LIT_ON,
      LIT_OFF
   } lit_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic       level;
      logic [7:0] data;
      logic       last;
   } rsp_load_type;

   function automatic logic is_delim(input logic [7:0] c);
      return (c == CH_LBR) || (c == CH_AT) || (c == CH_RBR);
   endfunction

   function automatic logic [3:0] lit_len(input lit_type id);
      logic [3:0] n;
      case (id)
         LIT_LED: n = 4'd3;
         LIT_NEW: n = 4'd9;
         LIT_ALR: n = 4'd12;
         LIT_ON:  n = 4'd2;
         LIT_OFF: n = 4'd3;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   // True when the character at offset k agrees with the literal, or lies past its end.
   function automatic logic lit_ok(input lit_type id, input logic [ADDR_W-1:0] k,
                                   input logic [7:0] c);
      logic [95:0] word;
      logic        ok;
      case (id)
         LIT_LED: word = {"LED", 72'h0};
         LIT_NEW: word = {" New conn", 24'h0};
         LIT_ALR: word = " Already log";
         LIT_ON:  word = {"ON", 80'h0};
         LIT_OFF: word = {"OFF", 72'h0};
         default: word = '0;
      endcase
      if (k >= ADDR_W'(lit_len(id))) begin
         ok = 1'b1;
      end else begin
         ok = (c == word[8*(11 - int'(k)) +: 8]);
      end
      return ok;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/ulcp_rsp_reg.sv -----
`default_nettype none

module ulcp_rsp_reg
   import ulcp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rsp_load_type       load,
   output logic                    out_free,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [TDATA_W-1:0]      rsp_tdata,   // bit 0 led_level, bits 8:1 tx_byte
   output logic [0:0]              rsp_tuser,   // bit 0 result_kind
   output logic                    rsp_tlast
);

   logic               valid_ff, valid_in;
   logic [TDATA_W-1:0] data_ff, data_in;
   logic [0:0]         user_ff, user_in;
   logic               last_ff, last_in;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      user_in  = user_ff;
      last_in  = last_ff;
      if (out_free) begin
         valid_in = load.valid;
         if (load.valid) begin
            data_in = {(TDATA_W - 9)'(0), load.data, load.level};
            user_in = load.kind;
            last_in = load.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ----- rtl/uart_line_command_parser_top.sv -----
`default_nettype none

// Collects received bytes into lines and, when a CR or LF closes a nonempty line, walks the
// stored line once to split it into tokens on '[', '@' and ']' and to compare the second and
// third tokens with the command words, then answers with an LED level or with a reply of the
// form "[t0]t1@t2" plus LF, one byte per transfer, cut to 63 bytes, or not at all. An ordinary
// byte is taken while the block is idle, and the block is ready again in the next cycle. A line
// end holds off the input while the stored line is read, once per character, through the single
// read port of the line memory, then while the block decides, then while the LED level or the
// reply bytes, whose token characters are read again through the same port, are handed on, and
// while the result side stalls. The line memory needs no clearing after reset.
module uart_line_command_parser_top
   import ulcp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         req_tdata,   // bits 7:0 rx_byte
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [TDATA_W-1:0]      rsp_tdata,   // bit 0 led_level, bits 8:1 tx_byte
   output logic [0:0]              rsp_tuser,   // bit 0 result_kind
   output logic                    rsp_tlast
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_DECIDE,
      ST_EMIT_LED,
      ST_EMIT_SEL,
      ST_EMIT_RD
   } state_type;

   typedef struct packed {
      logic led;
      logic fresh;
      logic already;
      logic on;
      logic off;
   } match_type;

   localparam logic [ADDR_W-1:0] LEN_FULL  = ADDR_W'(LINE_MAX - 1);
   localparam logic [ADDR_W-1:0] CNT_FINAL = ADDR_W'(REPLY_MAX - 1);
   localparam logic [TOK_W-1:0]  TOK_NONE  = TOK_W'(MIN_TOKENS);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] line_len_ff, line_len_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              in_tok_ff, in_tok_in;
   logic [TOK_W-1:0]  ntok_ff, ntok_in;
   logic [TOK_W-1:0]  tok_id_ff, tok_id_in;
   logic [ADDR_W-1:0] tstart_ff [MIN_TOKENS];
   logic [ADDR_W-1:0] tstart_in [MIN_TOKENS];
   logic [ADDR_W-1:0] tlen_ff [MIN_TOKENS];
   logic [ADDR_W-1:0] tlen_in [MIN_TOKENS];
   match_type         match_ff, match_in;
   logic              level_ff, level_in;
   logic [2:0]        seg_ff, seg_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;

   logic [7:0]        line_mem [LINE_MAX];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;

   rsp_load_type      load;
   logic              out_free;
   logic [7:0]        ch;
   logic [TOK_W-1:0]  tix;
   logic [ADDR_W-1:0] kcur;
   logic [7:0]        seg_char;

   assign req_tready = (state_ff == ST_IDLE);
   assign ch         = rd_data_ff;
   assign tix        = TOK_W'(seg_ff[2:1]);

   always_comb begin
      case (seg_ff)
         3'd0:    seg_char = CH_LBR;
         3'd2:    seg_char = CH_RBR;
         3'd4:    seg_char = CH_AT;
         default: seg_char = CH_LF;
      endcase
   end

   always_comb begin
      if (state_ff == ST_SCAN_RD) begin
         rd_addr = idx_ff;
      end else begin
         rd_addr = tstart_ff[tix] + k_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      line_len_in = line_len_ff;
      idx_in      = idx_ff;
      in_tok_in   = in_tok_ff;
      ntok_in     = ntok_ff;
      tok_id_in   = tok_id_ff;
      tstart_in   = tstart_ff;
      tlen_in     = tlen_ff;
      match_in    = match_ff;
      level_in    = level_ff;
      seg_in      = seg_ff;
      k_in        = k_ff;
      cnt_in      = cnt_ff;
      wr_en       = 1'b0;
      kcur        = '0;
      load        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if ((req_tdata == CH_CR) || (req_tdata == CH_LF)) begin
                  if (line_len_ff != '0) begin
                     idx_in    = '0;
                     in_tok_in = 1'b0;
                     ntok_in   = '0;
                     tok_id_in = TOK_NONE;
                     state_in  = ST_SCAN_RD;
                  end
               end else if (line_len_ff != LEN_FULL) begin
                  wr_en       = 1'b1;
                  line_len_in = line_len_ff + 1'b1;
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (ch == CH_NUL) begin
               state_in = ST_DECIDE;
            end else begin
               if (is_delim(ch)) begin
                  in_tok_in = 1'b0;
               end else if (!in_tok_ff) begin
                  in_tok_in = 1'b1;
                  tok_id_in = ntok_ff;
                  if (ntok_ff != TOK_NONE) begin
                     ntok_in            = ntok_ff + 1'b1;
                     tstart_in[ntok_ff] = idx_ff;
                     tlen_in[ntok_ff]   = ADDR_W'(1);
                     if (ntok_ff == TOK_W'(1)) begin
                        match_in.led     = lit_ok(LIT_LED, '0, ch);
                        match_in.fresh   = lit_ok(LIT_NEW, '0, ch);
                        match_in.already = lit_ok(LIT_ALR, '0, ch);
                     end else if (ntok_ff == TOK_W'(2)) begin
                        match_in.on  = lit_ok(LIT_ON, '0, ch);
                        match_in.off = lit_ok(LIT_OFF, '0, ch);
                     end
                  end
               end else if (tok_id_ff != TOK_NONE) begin
                  kcur               = tlen_ff[tok_id_ff];
                  tlen_in[tok_id_ff] = kcur + 1'b1;
                  if (tok_id_ff == TOK_W'(1)) begin
                     match_in.led     = match_ff.led && lit_ok(LIT_LED, kcur, ch);
                     match_in.fresh   = match_ff.fresh && lit_ok(LIT_NEW, kcur, ch);
                     match_in.already = match_ff.already && lit_ok(LIT_ALR, kcur, ch);
                  end else if (tok_id_ff == TOK_W'(2)) begin
                     match_in.on  = match_ff.on && lit_ok(LIT_ON, kcur, ch);
                     match_in.off = match_ff.off && lit_ok(LIT_OFF, kcur, ch);
                  end
               end
               if (idx_ff == line_len_ff - 1'b1) begin
                  state_in = ST_DECIDE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_DECIDE: begin
            line_len_in = '0;
            seg_in      = '0;
            k_in        = '0;
            cnt_in      = '0;
            if (ntok_ff != TOK_NONE) begin
               state_in = ST_IDLE;
            end else if ((match_ff.fresh && (tlen_ff[1] >= ADDR_W'(lit_len(LIT_NEW)))) ||
                         (match_ff.already && (tlen_ff[1] >= ADDR_W'(lit_len(LIT_ALR))))) begin
               state_in = ST_IDLE;
            end else if (match_ff.led && (tlen_ff[1] == ADDR_W'(lit_len(LIT_LED)))) begin
               if (match_ff.on && (tlen_ff[2] == ADDR_W'(lit_len(LIT_ON)))) begin
                  level_in = 1'b1;
                  state_in = ST_EMIT_LED;
               end else if (match_ff.off && (tlen_ff[2] == ADDR_W'(lit_len(LIT_OFF)))) begin
                  level_in = 1'b0;
                  state_in = ST_EMIT_LED;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_EMIT_SEL;
            end
         end
         ST_EMIT_LED: begin
            if (out_free) begin
               load.valid = 1'b1;
               load.kind  = KIND_LED;
               load.level = level_ff;
               load.last  = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_EMIT_SEL: begin
            if (seg_ff[0]) begin
               state_in = ST_EMIT_RD;
            end else if (out_free) begin
               load.valid = 1'b1;
               load.kind  = KIND_BYTE;
               load.data  = seg_char;
               load.last  = (cnt_ff == CNT_FINAL) || (seg_ff == 3'd6);
               cnt_in     = cnt_ff + 1'b1;
               seg_in     = seg_ff + 1'b1;
               k_in       = '0;
               if (load.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT_RD: begin
            if (out_free) begin
               load.valid = 1'b1;
               load.kind  = KIND_BYTE;
               load.data  = rd_data_ff;
               load.last  = (cnt_ff == CNT_FINAL);
               cnt_in     = cnt_ff + 1'b1;
               if (load.last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_EMIT_SEL;
                  if (k_ff + 1'b1 == tlen_ff[tix]) begin
                     seg_in = seg_ff + 1'b1;
                     k_in   = '0;
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[line_len_ff] <= req_tdata;
      end
      rd_data_ff <= line_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         line_len_ff <= '0;
      end else begin
         state_ff    <= state_in;
         line_len_ff <= line_len_in;
      end
      idx_ff    <= idx_in;
      in_tok_ff <= in_tok_in;
      ntok_ff   <= ntok_in;
      tok_id_ff <= tok_id_in;
      tstart_ff <= tstart_in;
      tlen_ff   <= tlen_in;
      match_ff  <= match_in;
      level_ff  <= level_in;
      seg_ff    <= seg_in;
      k_ff      <= k_in;
      cnt_ff    <= cnt_in;
   end

   ulcp_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- rtl/ulcp_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

module ulcp_checker
   import ulcp_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_tvalid,
   input wire logic               req_tready,
   input wire logic [7:0]         req_tdata,
   input wire logic               rsp_tvalid,
   input wire logic               rsp_tready,
   input wire logic [TDATA_W-1:0] rsp_tdata,
   input wire logic [0:0]         rsp_tuser,
   input wire logic               rsp_tlast
);

   `ULCP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
   `ULCP_ASSERT_SAME(a_led_is_last, clock, reset, rsp_tvalid && (rsp_tuser[0] == KIND_LED), rsp_tlast && (rsp_tdata[TDATA_W-1:1] == '0))
   `ULCP_ASSERT_SAME(a_byte_no_level, clock, reset, rsp_tvalid && (rsp_tuser[0] == KIND_BYTE), (rsp_tdata[0] == 1'b0) && (rsp_tdata[TDATA_W-1:9] == '0))
   `ULCP_ASSERT_NEXT(a_plain_byte_ready, clock, reset, req_tvalid && req_tready && (req_tdata != CH_CR) && (req_tdata != CH_LF), req_tready)

endmodule

bind uart_line_command_parser_top ulcp_checker u_ulcp_checker (.*);

`default_nettype wire

// ----- dv/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ulcp_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 9;
   localparam int MAX_TOKENS     = 5;
   localparam int RANDOM_BYTES   = 40;
   localparam int LONG_HOLD      = 400;
   localparam int TAIL_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REPORT_LIMIT   = 10;

   typedef enum {
      CHK_MODEL,
      CHK_NONE,
      CHK_LED_ON,
      CHK_LED_OFF
   } check_type;

   typedef struct packed {
      kind_type   kind;
      logic       level;
      logic [7:0] data;
      logic       last;
   } parser_out_type;

   typedef struct {
      string      text;
      int         nul_at;
      int         pad;
      logic [7:0] term;
      check_type  check;
      bit         stall_rx;
   } line_case_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata  = '0;
   check_type          req_check  = CHK_MODEL;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;
   logic [0:0]         rsp_tuser;
   logic               rsp_tlast;

   logic [7:0]     line_buf [LINE_MAX];
   int             line_len = 0;
   parser_out_type step_results[$];
   parser_out_type expected_out[$];
   logic [7:0]     line_bytes[$];
   line_case_type  cases[$];

   int mismatches   = 0;
   int burst_left   = 0;
   int random_bytes = 0;
   bit hold_wanted  = 1'b0;
   bit draining     = 1'b0;

   uart_line_command_parser_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic bit is_separator(input logic [7:0] c);
      return c == CH_LBR || c == CH_AT || c == CH_RBR;
   endfunction

   function automatic bit token_starts(input int s, input int n, input string lit);
      if (n < lit.len()) begin
         return 1'b0;
      end
      for (int i = 0; i < lit.len(); i++) begin
         if (line_buf[s + i] != lit[i]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic bit token_is(input int s, input int n, input string lit);
      return n == lit.len() && token_starts(s, n, lit);
   endfunction

   function automatic void put_reply(input logic [7:0] b);
      parser_out_type r;
      if (step_results.size() < REPLY_MAX) begin
         r.kind  = KIND_BYTE;
         r.level = 1'b0;
         r.data  = b;
         r.last  = 1'b0;
         step_results.push_back(r);
      end
   endfunction

   function automatic void put_token(input int s, input int n);
      for (int i = 0; i < n; i++) begin
         put_reply(line_buf[s + i]);
      end
   endfunction

   // Updates the line state with one byte and leaves in step_results what it causes.
   function automatic void absorb_byte(input logic [7:0] ch);
      int             text;
      int             ntok;
      int             i;
      int             tstart[MAX_TOKENS];
      int             tlen[MAX_TOKENS];
      parser_out_type r;
      step_results.delete();
      if (ch != CH_LF && ch != CH_CR) begin
         if (line_len < REPLY_MAX) begin
            line_buf[line_len] = ch;
            line_len++;
         end
         return;
      end
      if (line_len == 0) begin
         return;
      end
      text = 0;
      while (text < line_len && line_buf[text] != CH_NUL) begin
         text++;
      end
      line_len = 0;
      ntok = 0;
      i = 0;
      while (ntok < MAX_TOKENS) begin
         while (i < text && is_separator(line_buf[i])) begin
            i++;
         end
         if (i >= text) begin
            break;
         end
         tstart[ntok] = i;
         while (i < text && !is_separator(line_buf[i])) begin
            i++;
         end
         tlen[ntok] = i - tstart[ntok];
         ntok++;
      end
      if (ntok < MIN_TOKENS) begin
         return;
      end
      if (token_starts(tstart[1], tlen[1], " New conn") ||
          token_starts(tstart[1], tlen[1], " Already log")) begin
         return;
      end
      if (token_is(tstart[1], tlen[1], "LED")) begin
         r.kind = KIND_LED;
         r.data = 8'h00;
         r.last = 1'b1;
         if (token_is(tstart[2], tlen[2], "ON")) begin
            r.level = 1'b1;
         end else if (token_is(tstart[2], tlen[2], "OFF")) begin
            r.level = 1'b0;
         end else begin
            return;
         end
         step_results.push_back(r);
         return;
      end
      put_reply(CH_LBR);
      put_token(tstart[0], tlen[0]);
      put_reply(CH_RBR);
      put_token(tstart[1], tlen[1]);
      put_reply(CH_AT);
      put_token(tstart[2], tlen[2]);
      put_reply(CH_LF);
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
   endfunction

   function automatic void report_mismatch(input string what, input parser_out_type want,
                                           input parser_out_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%s: expected kind %0d level %0d byte %h last %0d,",
                  what, want.kind, want.level, want.data, want.last,
                  " got kind %0d level %0d byte %h last %0d",
                  got.kind, got.level, got.data, got.last);
      end
   endfunction

   // Typed expectations apply only to the line end that carries them.
   always @(posedge clock) begin
      parser_out_type r;
      if (!reset && req_tvalid && req_tready) begin
         absorb_byte(req_tdata);
         if (req_check != CHK_MODEL) begin
            step_results.delete();
            if (req_check != CHK_NONE) begin
               r.kind  = KIND_LED;
               r.level = (req_check == CHK_LED_ON);
               r.data  = 8'h00;
               r.last  = 1'b1;
               step_results.push_back(r);
            end
         end
         foreach (step_results[k]) begin
            expected_out.push_back(step_results[k]);
         end
      end
   end

   always @(posedge clock) begin
      parser_out_type got;
      parser_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind  = kind_type'(rsp_tuser[0]);
         got.level = rsp_tdata[0];
         got.data  = rsp_tdata[8:1];
         got.last  = rsp_tlast;
         if (expected_out.size() == 0) begin
            report_mismatch("result with nothing expected", parser_out_type'(0), got);
         end else begin
            want = expected_out.pop_front();
            if (got !== want) begin
               report_mismatch("wrong result", want, got);
            end
         end
      end
   end

   function automatic void add_case(input string text, input int nul_at, input int pad,
                                    input logic [7:0] term, input check_type check,
                                    input bit stall_rx);
      line_case_type c;
      c.text     = text;
      c.nul_at   = nul_at;
      c.pad      = pad;
      c.term     = term;
      c.check    = check;
      c.stall_rx = stall_rx;
      cases.push_back(c);
   endfunction

   function automatic void load_cases();
      add_case("[a]b@c", -1, 0, CH_LF, CHK_MODEL, 1'b0);
      add_case("", -1, 0, CH_CR, CHK_NONE, 1'b0);
      add_case("[d]LED@ON", -1, 0, CH_CR, CHK_LED_ON, 1'b0);
      add_case("[d]LED@OFF", -1, 0, CH_LF, CHK_LED_OFF, 1'b0);
      add_case("[d]LED@OFFX", -1, 0, CH_LF, CHK_NONE, 1'b0);
      add_case("[d]LED@on", -1, 0, CH_CR, CHK_NONE, 1'b0);
      add_case("[s] New conn@1", -1, 0, CH_CR, CHK_NONE, 1'b0);
      add_case("[s] Already log@2", -1, 0, CH_LF, CHK_NONE, 1'b0);
      add_case("[s] New con@3", -1, 0, CH_LF, CHK_MODEL, 1'b0);
      add_case("[d]LEDS@ON", -1, 0, CH_CR, CHK_MODEL, 1'b0);
      add_case("a@b", -1, 0, CH_LF, CHK_NONE, 1'b0);
      add_case("[[@@]]", -1, 0, CH_CR, CHK_NONE, 1'b0);
      add_case("@a]]b[c@", -1, 0, CH_LF, CHK_MODEL, 1'b0);
      add_case("a@b@c@d@e@f", -1, 0, CH_CR, CHK_MODEL, 1'b0);
      add_case("[x]y@z", 3, 0, CH_LF, CHK_NONE, 1'b0);
      add_case("[x]y@zzz", 7, 0, CH_CR, CHK_MODEL, 1'b0);
      add_case("[\001]\377@\200\177", -1, 0, CH_LF, CHK_MODEL, 1'b0);
      add_case("[p]q@", -1, 60, CH_LF, CHK_MODEL, 1'b1);
      add_case("[q]LED@ON", -1, 0, CH_CR, CHK_LED_ON, 1'b0);
      add_case("", -1, 0, CH_LF, CHK_NONE, 1'b0);
   endfunction

   function automatic void build_case_line(input line_case_type c);
      line_bytes.delete();
      for (int i = 0; i < c.text.len(); i++) begin
         if (i == c.nul_at) begin
            line_bytes.push_back(CH_NUL);
         end
         line_bytes.push_back(c.text[i]);
      end
      if (c.nul_at == c.text.len()) begin
         line_bytes.push_back(CH_NUL);
      end
      repeat (c.pad) begin
         line_bytes.push_back("q");
      end
   endfunction

   function automatic logic [7:0] token_char();
      logic [7:0] c;
      do begin
         if ($urandom_range(0, 9) < 7) begin
            c = 8'($urandom_range(32, 126));
         end else begin
            c = 8'($urandom_range(1, 255));
         end
      end while (c == CH_CR || c == CH_LF || is_separator(c));
      return c;
   endfunction

   function automatic void add_token(input int n);
      repeat (n) begin
         line_bytes.push_back(token_char());
      end
   endfunction

   function automatic void add_seps(input int n);
      repeat (n) begin
         case ($urandom_range(0, 2))
            0: line_bytes.push_back(CH_LBR);
            1: line_bytes.push_back(CH_AT);
            default: line_bytes.push_back(CH_RBR);
         endcase
      end
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         line_bytes.push_back(s[i]);
      end
   endfunction

   function automatic void build_random_line();
      int pick;
      int ntok;
      pick = $urandom_range(0, 99);
      line_bytes.delete();
      if (pick < 35) begin
         ntok = $urandom_range(3, 7);
         if ($urandom_range(0, 1)) begin
            add_seps($urandom_range(1, 2));
         end
         for (int t = 0; t < ntok; t++) begin
            if (t > 0) begin
               add_seps($urandom_range(1, 3));
            end
            add_token($urandom_range(1, 6));
         end
         if ($urandom_range(0, 1)) begin
            add_seps($urandom_range(1, 2));
         end
      end else if (pick < 50) begin
         line_bytes.push_back(CH_LBR);
         add_token($urandom_range(1, 4));
         add_text("]LED@");
         case ($urandom_range(0, 2))
            0: add_text("ON");
            1: add_text("OFF");
            default: add_token($urandom_range(1, 4));
         endcase
      end else if (pick < 60) begin
         line_bytes.push_back(CH_LBR);
         add_token($urandom_range(1, 4));
         line_bytes.push_back(CH_RBR);
         if ($urandom_range(0, 1)) begin
            add_text(" New conn");
         end else begin
            add_text(" Already log");
         end
         add_token($urandom_range(0, 4));
         line_bytes.push_back(CH_AT);
         add_token($urandom_range(1, 4));
      end else if (pick < 70) begin
         add_token($urandom_range(1, 5));
         if ($urandom_range(0, 1)) begin
            add_seps($urandom_range(1, 3));
            add_token($urandom_range(1, 5));
         end
      end else if (pick < 80) begin
         repeat ($urandom_range(1, 12)) begin
            line_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end else if (pick < 88) begin
         line_bytes.push_back(CH_LBR);
         add_token($urandom_range(1, 8));
         line_bytes.push_back(CH_RBR);
         add_token($urandom_range(1, 8));
         line_bytes.push_back(CH_AT);
         add_token($urandom_range(40, 80));
      end else begin
         line_bytes.push_back(CH_LBR);
         add_token($urandom_range(1, 4));
         line_bytes.push_back(CH_RBR);
         add_token($urandom_range(1, 4));
         line_bytes.push_back(CH_AT);
         add_token($urandom_range(1, 4));
         line_bytes.insert($urandom_range(0, line_bytes.size()), CH_NUL);
      end
   endfunction

   // The sender offers transfers in bursts; a short burst starts after a gap, a long one without.
   task automatic send_byte(input logic [7:0] b, input check_type chk);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(30, 60);
            gap = 0;
         end else begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(1, 8);
         end
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_check  <= chk;
      do begin
         @(posedge clock);
      end while (!req_tready);
      burst_left--;
   endtask

   // A long receiver hold starts as the line end is offered, so the reply backs up.
   task automatic send_line(input logic [7:0] term, input check_type chk, input bit stall_rx);
      foreach (line_bytes[i]) begin
         send_byte(line_bytes[i], CHK_MODEL);
      end
      if (stall_rx) begin
         hold_wanted = 1'b1;
      end
      send_byte(term, chk);
   endtask

   initial begin
      int span;
      int period;
      int mode;
      while (reset) @(posedge clock);
      forever begin
         if (draining) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            mode   = $urandom_range(0, 3);
            span   = $urandom_range(10, 60);
            period = $urandom_range(2, 5);
            for (int k = 0; k < span && !hold_wanted && !draining; k++) begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= 1'($urandom_range(0, 1));
                  2: rsp_tready <= (k % period == 0);
                  default: rsp_tready <= 1'b0;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      load_cases();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (cases[n]) begin
         build_case_line(cases[n]);
         send_line(cases[n].term, cases[n].check, cases[n].stall_rx);
      end
      while (random_bytes < RANDOM_BYTES) begin
         build_random_line();
         send_line($urandom_range(0, 1) ? CH_CR : CH_LF, CHK_MODEL, 1'b0);
         random_bytes += line_bytes.size() + 1;
      end
      req_tvalid <= 1'b0;
      draining = 1'b1;
      while (expected_out.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
